[src/lss_pkg.sv]
// Shared types, constants and helpers for the line substring search unit.
`timescale 1ns / 1ps

package lss_pkg;

    localparam int NEEDLE_MAX_DEF   = 16;
    localparam int OFFSET_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int NEEDLE_REG_BYTES = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int NEEDLE_LEN_W     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_CASE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ONLY   = 3'd4;

    localparam logic [7:0] NUL_BYTE = 8'h00;
    localparam logic [7:0] NL_BYTE  = 8'h0A;

    localparam logic RESULT_LINE    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } lss_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] line_num;
        logic [31:0] line_start;
        logic [31:0] match_offset;
        logic [31:0] line_end;
        logic        contains_nul;
        logic [31:0] match_count;
        logic        last;
    } lss_result_t;

    typedef struct packed {
        logic        has_line;
        logic        has_sum;
        logic [31:0] line_num;
        logic [31:0] line_start;
        logic [31:0] match_offset;
        logic [31:0] line_end;
        logic        contains_nul;
        logic [31:0] match_count;
    } lss_entry_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

[src/lss_front.sv]
// Front end: configuration registers, line window, needle compare and event building.
`timescale 1ns / 1ps

module lss_front
    import lss_pkg::*;
#(
    parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   take,
    input  lss_item_t              item,
    output logic                   entry_valid,
    output lss_entry_t             entry
);

    localparam int CNT_W = $clog2(NEEDLE_MAX + 1);

    function automatic logic [31:0] low32(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    logic [63:0]             needle_lo_reg;
    logic [63:0]             needle_hi_reg;
    logic [NEEDLE_LEN_W-1:0] needle_len_reg;
    logic                    ignore_case_reg;
    logic                    first_only_reg;

    logic [7:0]             win_reg   [NEEDLE_MAX];
    logic [7:0]             win_next  [NEEDLE_MAX];
    logic [7:0]             win_shift [NEEDLE_MAX];
    logic [7:0]             needle_byte [NEEDLE_MAX];
    logic [CNT_W-1:0]       bil_reg, bil_next, bil_new;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic [OFFSET_BITS-1:0] ls_reg, ls_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next, off_now, match_off, end_off;
    logic [31:0]            nc_reg, nc_next;
    logic [31:0]            hits_reg, hits_next, hits_after;
    logic                   hit_reg, hit_next;
    logic                   nul_reg, nul_next, nul_now;
    logic                   stopped_reg, stopped_next;

    logic [CNT_W-1:0]       eff_len;
    logic [127:0]           needle_all;
    logic [7:0]             aligned;
    logic                   match_ok;
    logic                   is_nl, is_eof, close, zero_hit, match_hit, hit_now, report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_lo_reg   <= '0;
            needle_hi_reg   <= '0;
            needle_len_reg  <= NEEDLE_LEN_W'(1);
            ignore_case_reg <= 1'b0;
            first_only_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEEDLE_LOW:  needle_lo_reg   <= cfg_data;
                REG_NEEDLE_HIGH: needle_hi_reg   <= cfg_data;
                REG_NEEDLE_LEN:  needle_len_reg  <= cfg_data[NEEDLE_LEN_W-1:0];
                REG_IGNORE_CASE: ignore_case_reg <= cfg_data[0];
                REG_FIRST_ONLY:  first_only_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign needle_all = {needle_hi_reg, needle_lo_reg};
    assign eff_len    = (int'(needle_len_reg) > NEEDLE_MAX) ? CNT_W'(NEEDLE_MAX)
                                                            : CNT_W'(needle_len_reg);

    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            if (i < NEEDLE_REG_BYTES)
            begin
                needle_byte[i] = needle_all[8*(i % NEEDLE_REG_BYTES) +: 8];
            end
            else
            begin
                needle_byte[i] = 8'd0;
            end
        end
    end

    always_comb
    begin
        win_shift[0] = item.data_byte;
        for (int k = 1; k < NEEDLE_MAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end
    end

    // window slot k holds the byte that lines up with needle byte eff_len-1-k
    always_comb
    begin
        match_ok = 1'b1;
        aligned  = 8'd0;
        for (int k = 0; k < NEEDLE_MAX; k++)
        begin
            aligned = 8'd0;
            for (int j = 0; j < NEEDLE_MAX; j++)
            begin
                if (j + k + 1 == int'(eff_len))
                begin
                    aligned = needle_byte[j];
                end
            end
            if (k < int'(eff_len) &&
                fold(win_shift[k], ignore_case_reg) != fold(aligned, ignore_case_reg))
            begin
                match_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        is_nl     = (item.data_byte == NL_BYTE);
        is_eof    = item.end_of_file;
        close     = is_nl || is_eof;
        pos_inc   = sat_inc_off(pos_reg);
        nul_now   = nul_reg || (item.data_byte == NUL_BYTE);
        bil_new   = (int'(bil_reg) == NEEDLE_MAX) ? bil_reg : bil_reg + 1'b1;
        match_off = pos_reg + 1'b1 - OFFSET_BITS'(eff_len);
        zero_hit  = (eff_len == '0) && (bil_reg == '0);
        match_hit = !is_nl && (eff_len != '0) && (bil_new >= eff_len) && match_ok;
        hit_now   = hit_reg || (!stopped_reg && (zero_hit || match_hit));
        if (hit_reg || stopped_reg)
        begin
            off_now = off_reg;
        end
        else if (zero_hit)
        begin
            off_now = pos_reg;
        end
        else
        begin
            off_now = match_off;
        end
        end_off    = (!is_nl && is_eof) ? pos_inc : pos_reg;
        report     = close && hit_now;
        hits_after = report ? sat_inc32(hits_reg) : hits_reg;

        entry.has_line     = report;
        entry.has_sum      = is_eof;
        entry.line_num     = sat_inc32(nc_reg);
        entry.line_start   = low32(ls_reg);
        entry.match_offset = low32(off_now);
        entry.line_end     = low32(end_off);
        entry.contains_nul = nul_now;
        entry.match_count  = hits_after;
        entry_valid        = take && (report || is_eof);
    end

    always_comb
    begin
        win_next     = win_reg;
        bil_next     = bil_reg;
        pos_next     = pos_reg;
        ls_next      = ls_reg;
        off_next     = off_reg;
        nc_next      = nc_reg;
        hits_next    = hits_reg;
        hit_next     = hit_reg;
        nul_next     = nul_reg;
        stopped_next = stopped_reg;
        if (take)
        begin
            pos_next = pos_inc;
            nul_next = nul_now;
            hit_next = hit_now;
            off_next = off_now;
            if (!is_nl)
            begin
                win_next = win_shift;
                bil_next = bil_new;
            end
            if (close)
            begin
                hit_next = 1'b0;
                off_next = '0;
                bil_next = '0;
                win_next = '{default: '0};
                ls_next  = pos_inc;
                if (is_nl)
                begin
                    nc_next = sat_inc32(nc_reg);
                end
                if (report)
                begin
                    hits_next = hits_after;
                    if (first_only_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
            if (is_eof)
            begin
                win_next     = '{default: '0};
                bil_next     = '0;
                pos_next     = '0;
                ls_next      = '0;
                off_next     = '0;
                nc_next      = '0;
                hits_next    = '0;
                hit_next     = 1'b0;
                nul_next     = 1'b0;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '{default: '0};
            bil_reg     <= '0;
            pos_reg     <= '0;
            ls_reg      <= '0;
            off_reg     <= '0;
            nc_reg      <= '0;
            hits_reg    <= '0;
            hit_reg     <= 1'b0;
            nul_reg     <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            win_reg     <= win_next;
            bil_reg     <= bil_next;
            pos_reg     <= pos_next;
            ls_reg      <= ls_next;
            off_reg     <= off_next;
            nc_reg      <= nc_next;
            hits_reg    <= hits_next;
            hit_reg     <= hit_next;
            nul_reg     <= nul_next;
            stopped_reg <= stopped_next;
        end
    end

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_file |=> pos_reg == '0 && !stopped_reg && !hit_reg && hits_reg == '0)
        else $error("state not cleared after end of file");

endmodule

[src/lss_queue.sv]
// Short event queue between the front end and the result stage.
`timescale 1ns / 1ps

module lss_queue
    import lss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  lss_entry_t wr_data,
    input  logic       rd_en,
    output lss_entry_t rd_data,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lss_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign full    = (int'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full || rd_en)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("read from an empty queue");

endmodule

[src/lss_back.sv]
// Result stage: holds one queued event and hands out its line report and summary.
`timescale 1ns / 1ps

module lss_back
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  lss_entry_t  q_data,
    output logic        q_pop,
    output lss_result_t result,
    output logic        empty,
    input  logic        pop
);

    lss_entry_t ent_reg, ent_next;
    logic       valid_reg, valid_next;
    logic       line_done_reg, line_done_next;
    logic       show_line, transfer, finish, load;

    always_comb
    begin
        show_line = ent_reg.has_line && !line_done_reg;
        transfer  = pop && valid_reg;
        finish    = transfer && !(show_line && ent_reg.has_sum);
        load      = !q_empty && (!valid_reg || finish);
        q_pop     = load;
        empty     = !valid_reg;

        ent_next       = ent_reg;
        valid_next     = valid_reg;
        line_done_next = line_done_reg;
        if (load)
        begin
            ent_next       = q_data;
            valid_next     = 1'b1;
            line_done_next = 1'b0;
        end
        else if (finish)
        begin
            valid_next = 1'b0;
        end
        else if (transfer)
        begin
            line_done_next = 1'b1;
        end
    end

    always_comb
    begin
        result.result_kind  = show_line ? RESULT_LINE : RESULT_SUMMARY;
        result.line_num     = show_line ? ent_reg.line_num     : 32'd0;
        result.line_start   = show_line ? ent_reg.line_start   : 32'd0;
        result.match_offset = show_line ? ent_reg.match_offset : 32'd0;
        result.line_end     = show_line ? ent_reg.line_end     : 32'd0;
        result.contains_nul = show_line ? 1'b0 : ent_reg.contains_nul;
        result.match_count  = show_line ? 32'd0 : ent_reg.match_count;
        result.last         = !show_line;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            line_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            line_done_reg <= line_done_next;
        end
    end

    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && pop && show_line && ent_reg.has_sum
        |=> valid_reg && line_done_reg && $stable(ent_reg))
        else $error("summary lost after line report");

endmodule

[src/line_substring_search_unit.sv]
// Top level of the line substring search unit.
`timescale 1ns / 1ps

// Searches a byte stream for a fixed needle of up to 16 bytes and reports the first hit
// of each line (only one line if first_only is set), plus a summary after the byte flagged
// end_of_file. One byte is taken every cycle while full is low; the compare of the needle
// against the line window finishes in the cycle the byte arrives, and each event goes through
// a queue of QUEUE_DEPTH entries to the result stage, which hands out one result per cycle.
// A line ending on the end-of-file byte with a hit gives two results, so full rises whenever
// results come faster than the consumer pops them; a run of one-byte files that each hit
// does this even with pop held high. Configuration writes take effect on the next edge.
module line_substring_search_unit
    import lss_pkg::*;
#(
    parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  lss_item_t              item,
    output logic                   empty,
    input  logic                   pop,
    output lss_result_t            result
);

    logic       take;
    logic       ev_valid;
    lss_entry_t ev_data;
    logic       q_pop;
    logic       q_empty;
    lss_entry_t q_data;

    assign take = push && !full;

    lss_front #(
        .NEEDLE_MAX  (NEEDLE_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .item        (item),
        .entry_valid (ev_valid),
        .entry       (ev_data)
    );

    lss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_valid),
        .wr_data (ev_data),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    lss_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
